// ===== rtl/tcd_pkg.sv =====
// Shared types and constants for the timestamp-to-calendar-date unit.
// Holds the reciprocal constants for the constant dividers and the month-start table.
// No dependencies.
package tcd_pkg;

  // Seconds and day constants.
  localparam logic [31:0] SEC_PER_DAY  = 32'd86400;
  localparam logic [16:0] SEC_PER_HOUR = 17'd3600;
  localparam logic [11:0] SEC_PER_MIN  = 12'd60;

  // Reciprocals for the constant dividers. The ceiling forms give exact quotients
  // over the full operand range. DAY_RECIP is a floor form and needs one correction.
  localparam logic [15:0] DAY_RECIP   = 16'd49710;   // 2^25 / 675, floor
  localparam logic [18:0] LEAP4_RECIP = 19'd367720;  // 2^29 / 1460, ceiling
  localparam logic [18:0] YEAR_RECIP  = 19'd367720;  // 2^27 / 365, ceiling
  localparam logic [11:0] MONTH_RECIP = 12'd3427;    // 2^19 / 153, ceiling
  localparam logic [16:0] WEEK_RECIP  = 17'd74899;   // 2^19 / 7, ceiling
  localparam logic [17:0] HOUR_RECIP  = 18'd149131;  // 2^29 / 3600, ceiling
  localparam logic [12:0] MIN_RECIP   = 13'd4370;    // 2^18 / 60, ceiling

  // Cycles from an accepted beat to its result strobe.
  localparam int unsigned PIPE_DEPTH = 8;

  // Day count and seconds of day leaving the day split.
  typedef struct packed {
    logic [15:0] days;
    logic [16:0] sod;
  } tcd_split_t;

  // Time of day carried down the delay stages.
  typedef struct packed {
    logic [4:0] hour;
    logic [5:0] minute;
    logic [5:0] second;
  } tcd_hms_t;

  // First day of each March-based month within the year: (153 * m + 2) / 5.
  function automatic logic [8:0] month_start(input logic [3:0] mp);
    logic [8:0] res;
    case (mp)
      4'd0:    res = 9'd0;
      4'd1:    res = 9'd31;
      4'd2:    res = 9'd61;
      4'd3:    res = 9'd92;
      4'd4:    res = 9'd122;
      4'd5:    res = 9'd153;
      4'd6:    res = 9'd184;
      4'd7:    res = 9'd214;
      4'd8:    res = 9'd245;
      4'd9:    res = 9'd275;
      4'd10:   res = 9'd306;
      4'd11:   res = 9'd337;
      default: res = 9'd0;
    endcase
    return res;
  endfunction

endpackage

// ===== rtl/tcd_day_split.sv =====
// Two-stage split of the timestamp into a day count and the seconds of the day.
// Depends on tcd_pkg.
module tcd_day_split
  import tcd_pkg::*;
(
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_v,
  input  logic [31:0] in_secs,
  output logic        out_v,
  output tcd_split_t  out_split
);

  logic [40:0] qprod;
  logic [15:0] q0_nxt;
  logic [15:0] q0_r;
  logic [31:0] secs1_r;
  logic        v1_r;
  logic        v2_r;
  logic [31:0] base;
  logic [31:0] rem;
  logic        wrap;
  tcd_split_t  split_nxt;
  tcd_split_t  split_r;

  // Estimate t / 86400 as (t >> 7) / 675; low by at most one.
  assign qprod  = 41'(in_secs[31:7]) * 41'(DAY_RECIP);
  assign q0_nxt = qprod[40:25];

  // Fix the estimate with one compare and subtract.
  assign base = 32'(q0_r) * SEC_PER_DAY;
  assign rem  = secs1_r - base;
  assign wrap = (rem >= SEC_PER_DAY);

  always_comb begin
    split_nxt.days = q0_r + 16'(wrap);
    split_nxt.sod  = wrap ? 17'(rem - SEC_PER_DAY) : 17'(rem);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v1_r <= 1'b0;
      v2_r <= 1'b0;
    end else begin
      v1_r <= in_v;
      v2_r <= v1_r;
    end
  end

  always_ff @(posedge clk) begin
    q0_r    <= q0_nxt;
    secs1_r <= in_secs;
    split_r <= split_nxt;
  end

  assign out_v     = v2_r;
  assign out_split = split_r;

endmodule

// ===== rtl/tcd_civil_date.sv =====
// Six-stage day-count to civil date and weekday pipeline (400-year era method).
// Depends on tcd_pkg.
module tcd_civil_date
  import tcd_pkg::*;
(
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_v,
  input  logic [15:0] in_days,
  output logic        out_v,
  output logic [11:0] out_year,
  output logic [3:0]  out_month,
  output logic [4:0]  out_dom,
  output logic [2:0]  out_dow
);

  localparam logic [19:0] MAR0_SHIFT = 20'd719468;
  localparam logic [19:0] ERA5_START = 20'd730485;
  localparam logic [19:0] ERA4_START = 20'd584388;
  localparam logic [17:0] CENT1      = 18'd36524;
  localparam logic [17:0] CENT2      = 18'd73048;
  localparam logic [17:0] CENT3      = 18'd109572;
  localparam logic [17:0] ERA_LAST   = 18'd146096;

  logic [5:0]  v_r;

  // Stage 1: era and day of era; weekday quotient.
  logic [19:0] z;
  logic        era5_nxt;
  logic [17:0] doe1_nxt;
  logic [15:0] w;
  logic [32:0] wprod;
  logic        era5_1_r;
  logic [17:0] doe1_r;
  logic [15:0] w1_r;
  logic [12:0] wq1_r;

  // Stage 2: leap-day corrected day of era; weekday remainder.
  logic [36:0] aprod;
  logic [7:0]  a;
  logic [2:0]  cent;
  logic        era_end;
  logic [17:0] n2_nxt;
  logic [15:0] wm;
  logic [17:0] n2_r;
  logic [17:0] doe2_r;
  logic        era5_2_r;
  logic [2:0]  dow2_r;

  // Stage 3: year of era.
  logic [36:0] yprod;
  logic [8:0]  yoe3_r;
  logic [17:0] doe3_r;
  logic        era5_3_r;
  logic [2:0]  dow3_r;

  // Stage 4: day of the March-based year.
  logic [1:0]  c100;
  logic [17:0] ydays;
  logic [17:0] doy_full;
  logic [8:0]  doy4_r;
  logic [8:0]  yoe4_r;
  logic        era5_4_r;
  logic [2:0]  dow4_r;

  // Stage 5: March-based month.
  logic [10:0] mx;
  logic [22:0] mprod;
  logic [3:0]  mp5_r;
  logic [8:0]  doy5_r;
  logic [8:0]  yoe5_r;
  logic        era5_5_r;
  logic [2:0]  dow5_r;

  // Stage 6: final fields.
  logic [8:0]  dom_full;
  logic [3:0]  month_nxt;
  logic [11:0] year_nxt;
  logic [11:0] year_r;
  logic [3:0]  month_r;
  logic [4:0]  dom_r;
  logic [2:0]  dow6_r;

  assign z        = 20'(in_days) + MAR0_SHIFT;
  assign era5_nxt = (z >= ERA5_START);
  assign doe1_nxt = era5_nxt ? 18'(z - ERA5_START) : 18'(z - ERA4_START);
  assign w        = in_days + 16'd4;
  assign wprod    = 33'(w) * 33'(WEEK_RECIP);

  assign aprod   = 37'(doe1_r) * 37'(LEAP4_RECIP);
  assign a       = aprod[36:29];
  assign cent    = (doe1_r >= ERA_LAST) ? 3'd4 :
                   (doe1_r >= CENT3)    ? 3'd3 :
                   (doe1_r >= CENT2)    ? 3'd2 :
                   (doe1_r >= CENT1)    ? 3'd1 : 3'd0;
  assign era_end = (doe1_r == ERA_LAST);
  assign n2_nxt  = doe1_r - 18'(a) + 18'(cent) - 18'(era_end);
  assign wm      = w1_r - 16'(16'(wq1_r) * 16'd7);

  assign yprod = 37'(n2_r) * 37'(YEAR_RECIP);

  assign c100     = (yoe3_r >= 9'd300) ? 2'd3 :
                    (yoe3_r >= 9'd200) ? 2'd2 :
                    (yoe3_r >= 9'd100) ? 2'd1 : 2'd0;
  assign ydays    = 18'(18'(yoe3_r) * 18'd365) + 18'(yoe3_r[8:2]) - 18'(c100);
  assign doy_full = doe3_r - ydays;

  assign mx    = 11'(11'(doy4_r) * 11'd5 + 11'd2);
  assign mprod = 23'(mx) * 23'(MONTH_RECIP);

  assign dom_full  = doy5_r - month_start(mp5_r) + 9'd1;
  assign month_nxt = (mp5_r < 4'd10) ? (mp5_r + 4'd3) : (mp5_r - 4'd9);
  assign year_nxt  = 12'(yoe5_r) + (era5_5_r ? 12'd2000 : 12'd1600)
                   + 12'(month_nxt <= 4'd2);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v_r <= '0;
    end else begin
      v_r <= {v_r[4:0], in_v};
    end
  end

  always_ff @(posedge clk) begin
    era5_1_r <= era5_nxt;
    doe1_r   <= doe1_nxt;
    w1_r     <= w;
    wq1_r    <= wprod[31:19];

    n2_r     <= n2_nxt;
    doe2_r   <= doe1_r;
    era5_2_r <= era5_1_r;
    dow2_r   <= wm[2:0];

    yoe3_r   <= yprod[35:27];
    doe3_r   <= doe2_r;
    era5_3_r <= era5_2_r;
    dow3_r   <= dow2_r;

    doy4_r   <= doy_full[8:0];
    yoe4_r   <= yoe3_r;
    era5_4_r <= era5_3_r;
    dow4_r   <= dow3_r;

    mp5_r    <= mprod[22:19];
    doy5_r   <= doy4_r;
    yoe5_r   <= yoe4_r;
    era5_5_r <= era5_4_r;
    dow5_r   <= dow4_r;

    year_r   <= year_nxt;
    month_r  <= month_nxt;
    dom_r    <= dom_full[4:0];
    dow6_r   <= dow5_r;
  end

  assign out_v     = v_r[5];
  assign out_year  = year_r;
  assign out_month = month_r;
  assign out_dom   = dom_r;
  assign out_dow   = dow6_r;

endmodule

// ===== rtl/tcd_clock_time.sv =====
// Six-stage seconds-of-day to hour, minute and second pipeline.
// Depends on tcd_pkg.
module tcd_clock_time
  import tcd_pkg::*;
(
  input  logic        clk,
  input  logic [16:0] in_sod,
  output tcd_hms_t    out_hms
);

  logic [34:0] hprod;
  logic [4:0]  hour1_r;
  logic [16:0] sod1_r;
  logic [11:0] ms2_nxt;
  logic [11:0] ms2_r;
  logic [4:0]  hour2_r;
  logic [24:0] mprod;
  logic [5:0]  min3_r;
  logic [11:0] ms3_r;
  logic [4:0]  hour3_r;
  logic [11:0] sec_full;
  tcd_hms_t    hms4_nxt;
  tcd_hms_t    hms4_r;
  tcd_hms_t    hms5_r;
  tcd_hms_t    hms6_r;

  assign hprod   = 35'(in_sod) * 35'(HOUR_RECIP);
  assign ms2_nxt = 12'(sod1_r - 17'(17'(hour1_r) * SEC_PER_HOUR));
  assign mprod   = 25'(ms2_r) * 25'(MIN_RECIP);
  assign sec_full = ms3_r - 12'(12'(min3_r) * SEC_PER_MIN);

  always_comb begin
    hms4_nxt.hour   = hour3_r;
    hms4_nxt.minute = min3_r;
    hms4_nxt.second = sec_full[5:0];
  end

  // Hold alignment with the date path: two plain delay stages at the end.
  always_ff @(posedge clk) begin
    hour1_r <= hprod[33:29];
    sod1_r  <= in_sod;
    ms2_r   <= ms2_nxt;
    hour2_r <= hour1_r;
    min3_r  <= mprod[23:18];
    ms3_r   <= ms2_r;
    hour3_r <= hour2_r;
    hms4_r  <= hms4_nxt;
    hms5_r  <= hms4_r;
    hms6_r  <= hms5_r;
  end

  assign out_hms = hms6_r;

endmodule

// ===== rtl/timestamp_to_calendar_date_unit.sv =====
// Top level of the timestamp-to-calendar-date unit.
// Depends on tcd_pkg, tcd_day_split, tcd_civil_date and tcd_clock_time.
//
//   channel   ports                            handshake
//   --------  -------------------------------  ------------------------------------
//   input     in_seconds_since_epoch           start high and busy low at the edge
//   result    out_calendar_year .. out_day_of_week  out_valid high for one cycle
//
// A beat is taken every cycle; busy stays low, since nothing downstream can stall.
// Each result passes two stages of day split, then six stages of date and
// time-of-day, each about one constant multiply plus a few adds or compares
// deep. rst_n (synchronous) clears only the valid bits; payload registers hold
// whatever they last captured.
module timestamp_to_calendar_date_unit
  import tcd_pkg::*;
(
  input  logic        clk,
  input  logic        rst_n,
  input  logic        start,
  output logic        busy,
  input  logic [31:0] in_seconds_since_epoch,
  output logic        out_valid,
  output logic [11:0] out_calendar_year,
  output logic [3:0]  out_month_number,
  output logic [4:0]  out_day_of_month,
  output logic [4:0]  out_hour_of_day,
  output logic [5:0]  out_minute_of_hour,
  output logic [5:0]  out_second_of_minute,
  output logic [2:0]  out_day_of_week
);

  logic       split_v;
  tcd_split_t split;
  tcd_hms_t   hms;

  // Never stall the input: every stage advances every cycle.
  assign busy = 1'b0;

  // Split seconds into day count and seconds of day.
  tcd_day_split u_split (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_v     (start & ~busy),
    .in_secs  (in_seconds_since_epoch),
    .out_v    (split_v),
    .out_split(split)
  );

  // Date and weekday lane; its valid chain marks the result beat.
  tcd_civil_date u_date (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_v     (split_v),
    .in_days  (split.days),
    .out_v    (out_valid),
    .out_year (out_calendar_year),
    .out_month(out_month_number),
    .out_dom  (out_day_of_month),
    .out_dow  (out_day_of_week)
  );

  // Time-of-day lane, same depth as the date lane.
  tcd_clock_time u_time (
    .clk    (clk),
    .in_sod (split.sod),
    .out_hms(hms)
  );

  assign out_hour_of_day      = hms.hour;
  assign out_minute_of_hour   = hms.minute;
  assign out_second_of_minute = hms.second;

  // A result strobe always traces back to an accepted beat a fixed depth earlier.
  a_strobe_origin: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> $past(start, PIPE_DEPTH))
    else $error("result strobe without matching input beat");

  // Calendar fields stay in range.
  a_date_range: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> (out_month_number >= 4'd1 && out_month_number <= 4'd12 &&
                   out_day_of_month != 5'd0 && out_day_of_week <= 3'd6 &&
                   out_calendar_year >= 12'd1970 && out_calendar_year <= 12'd2106))
    else $error("calendar field out of range");

  // Time-of-day fields stay in range.
  a_time_range: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> (out_hour_of_day <= 5'd23 && out_minute_of_hour <= 6'd59 &&
                   out_second_of_minute <= 6'd59))
    else $error("time-of-day field out of range");

endmodule

// ===== test/calendar_date_checker.sv =====
// Checker for the timestamp-to-calendar-date unit: it watches both channels,
// predicts the date and time of day for each accepted beat and compares.
// Depends on nothing but the unit's port widths.
`timescale 1ns / 100ps

module calendar_date_checker (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        start,
  input  logic        busy,
  input  logic [31:0] in_seconds_since_epoch,
  input  logic        out_valid,
  input  logic [11:0] out_calendar_year,
  input  logic [3:0]  out_month_number,
  input  logic [4:0]  out_day_of_month,
  input  logic [4:0]  out_hour_of_day,
  input  logic [5:0]  out_minute_of_hour,
  input  logic [5:0]  out_second_of_minute,
  input  logic [2:0]  out_day_of_week,
  output int          fail_count,
  output int          pending_count
);

  typedef struct packed {
    logic [11:0] year;
    logic [3:0]  month;
    logic [4:0]  mday;
    logic [4:0]  hour;
    logic [5:0]  minute;
    logic [5:0]  second;
    logic [2:0]  wday;
  } civil_stamp_t;

  civil_stamp_t pending_dates[$];

  // Split seconds into days and time of day, then walk 400-year cycles with a
  // year that starts in March, so the leap day falls at the end of the year.
  function automatic civil_stamp_t civil_date_of(input logic [31:0] secs);
    logic [31:0] days, sod, shifted, cycle, day_in_cycle, year_in_cycle;
    logic [31:0] day_in_year, mar_month, mday, month, year;
    civil_stamp_t stamp;
    days          = secs / 32'd86400;
    sod           = secs - days * 32'd86400;
    shifted       = days + 32'd719468;
    cycle         = shifted / 32'd146097;
    day_in_cycle  = shifted - cycle * 32'd146097;
    year_in_cycle = (day_in_cycle - day_in_cycle / 32'd1460 + day_in_cycle / 32'd36524
                     - day_in_cycle / 32'd146096) / 32'd365;
    day_in_year   = day_in_cycle - (32'd365 * year_in_cycle + year_in_cycle / 32'd4
                                    - year_in_cycle / 32'd100);
    mar_month     = (32'd5 * day_in_year + 32'd2) / 32'd153;
    mday          = day_in_year - (32'd153 * mar_month + 32'd2) / 32'd5 + 32'd1;
    month         = (mar_month < 32'd10) ? mar_month + 32'd3 : mar_month - 32'd9;
    year          = year_in_cycle + cycle * 32'd400 + ((month <= 32'd2) ? 32'd1 : 32'd0);
    stamp.year    = year[11:0];
    stamp.month   = month[3:0];
    stamp.mday    = mday[4:0];
    stamp.hour    = 5'(sod / 32'd3600);
    stamp.minute  = 6'((sod / 32'd60) % 32'd60);
    stamp.second  = 6'(sod % 32'd60);
    stamp.wday    = 3'((days + 32'd4) % 32'd7);
    return stamp;
  endfunction

  task automatic check_field(input string label, input int unsigned want,
                             input int unsigned got);
    if (want != got) begin
      $display("%0t: %s mismatch, expected %0d, got %0d", $time, label, want, got);
      fail_count++;
    end
  endtask

  always @(posedge clk) begin
    civil_stamp_t want;
    if (rst_n) begin
      // Retire the result on the outputs before taking the new beat.
      if (out_valid) begin
        if (pending_dates.size() == 0) begin
          $display("%0t: result with nothing outstanding, year %0d month %0d day %0d",
                   $time, out_calendar_year, out_month_number, out_day_of_month);
          fail_count++;
        end else begin
          want = pending_dates.pop_front();
          check_field("year",    want.year,   out_calendar_year);
          check_field("month",   want.month,  out_month_number);
          check_field("mday",    want.mday,   out_day_of_month);
          check_field("hour",    want.hour,   out_hour_of_day);
          check_field("minute",  want.minute, out_minute_of_hour);
          check_field("second",  want.second, out_second_of_minute);
          check_field("weekday", want.wday,   out_day_of_week);
        end
      end
      if (start && !busy)
        pending_dates.push_back(civil_date_of(in_seconds_since_epoch));
    end
    pending_count = pending_dates.size();
  end

endmodule

// ===== test/tb.sv =====
// Top of the testbench for the timestamp-to-calendar-date unit: clock, reset,
// timestamp stimulus and the verdict. Depends on tcd_pkg, the unit and
// calendar_date_checker, which does all prediction and comparison.
`timescale 1ns / 100ps

module tb
  import tcd_pkg::*;
();

  localparam int RANDOM_BEATS = 2000;
  localparam logic [31:0] LAST_SECOND = 32'hFFFF_FFFF;

  // Calendar corners: epoch, day edges, leap days in a 4-year, 400-year and
  // skipped-century year, year turnover, the signed 32-bit rollover and the
  // last representable second (early February 2106).
  localparam logic [31:0] CORNER_STAMPS[18] = '{
    32'd0,          32'd1,          32'd86399,      32'd86400,
    32'd5097600,    32'd68169600,   32'd94694399,   32'd946684799,
    32'd946684800,  32'd951782400,  32'd951868799,  32'd951868800,
    32'd2147483647, 32'd2147483648, 32'd4107542399, 32'd4107542400,
    32'd4294944000, LAST_SECOND
  };

  logic        clk = 1'b0;
  logic        rst_n = 1'b0;
  logic        start = 1'b0;
  logic [31:0] in_seconds_since_epoch = '0;
  logic        busy;
  logic        out_valid;
  logic [11:0] out_calendar_year;
  logic [3:0]  out_month_number;
  logic [4:0]  out_day_of_month;
  logic [4:0]  out_hour_of_day;
  logic [5:0]  out_minute_of_hour;
  logic [5:0]  out_second_of_minute;
  logic [2:0]  out_day_of_week;
  int          fail_count;
  int          pending_count;

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  timestamp_to_calendar_date_unit DUT (
    .clk                   (clk),
    .rst_n                 (rst_n),
    .start                 (start),
    .busy                  (busy),
    .in_seconds_since_epoch(in_seconds_since_epoch),
    .out_valid             (out_valid),
    .out_calendar_year     (out_calendar_year),
    .out_month_number      (out_month_number),
    .out_day_of_month      (out_day_of_month),
    .out_hour_of_day       (out_hour_of_day),
    .out_minute_of_hour    (out_minute_of_hour),
    .out_second_of_minute  (out_second_of_minute),
    .out_day_of_week       (out_day_of_week)
  );

  calendar_date_checker u_checker (
    .clk                   (clk),
    .rst_n                 (rst_n),
    .start                 (start),
    .busy                  (busy),
    .in_seconds_since_epoch(in_seconds_since_epoch),
    .out_valid             (out_valid),
    .out_calendar_year     (out_calendar_year),
    .out_month_number      (out_month_number),
    .out_day_of_month      (out_day_of_month),
    .out_hour_of_day       (out_hour_of_day),
    .out_minute_of_hour    (out_minute_of_hour),
    .out_second_of_minute  (out_second_of_minute),
    .out_day_of_week       (out_day_of_week),
    .fail_count            (fail_count),
    .pending_count         (pending_count)
  );

  // Present one beat and hold it until an edge sees start high with busy low.
  // Leave start high on return so a back-to-back beat needs no second write.
  task automatic send_stamp(input logic [31:0] secs);
    start                  <= 1'b1;
    in_seconds_since_epoch <= secs;
    do @(posedge clk); while (busy);
  endtask

  // Drop start and put noise on the data lines while idle; an n of zero does nothing.
  task automatic idle_cycles(input int unsigned n);
    if (n != 0) begin
      start                  <= 1'b0;
      in_seconds_since_epoch <= $urandom;
      repeat (n) @(posedge clk);
    end
  endtask

  // Pick a timestamp: mostly uniform, the rest aimed at day, hour and minute
  // edges, the first days after the epoch and the last days before overflow.
  function automatic logic [31:0] pick_stamp();
    logic [31:0] day_start;
    logic [31:0] edge_offs[6];
    edge_offs = '{32'd0, 32'd1, 32'd59, 32'd3599, 32'd3600, 32'd86399};
    day_start = 32'($urandom_range(0, 49709)) * 32'd86400;
    case ($urandom_range(0, 9))
      6, 7:    return day_start + edge_offs[$urandom_range(0, 5)];
      8:       return 32'($urandom_range(0, 3 * 86400));
      9:       return LAST_SECOND - 32'($urandom_range(0, 400000));
      default: return $urandom;
    endcase
  endfunction

  // Hard stop in case the unit never drains.
  initial begin
    #(5_000_000);
    $display("tb: failure");
    $finish;
  end

  initial begin
    int unsigned sent;
    int unsigned burst;
    repeat (10) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // Directed corners, back to back.
    foreach (CORNER_STAMPS[i])
      send_stamp(CORNER_STAMPS[i]);
    idle_cycles(3);

    // Random bursts; every fourth burst or so runs with no gap after it so
    // long unbroken streams go through the pipeline too.
    sent = 0;
    while (sent < RANDOM_BEATS) begin
      burst = $urandom_range(1, 24);
      repeat (burst) begin
        send_stamp(pick_stamp());
        sent++;
      end
      if ($urandom_range(0, 3) != 0)
        idle_cycles($urandom_range(1, 9));
    end
    start <= 1'b0;

    // Drain: wait for every outstanding date, then give stray strobes a
    // chance to show. Read checker counts away from the active edge.
    @(negedge clk);
    while (pending_count != 0) @(negedge clk);
    repeat (PIPE_DEPTH + 4) @(negedge clk);

    if (fail_count == 0)
      $display("tb: success");
    else
      $display("tb: failure");
    $finish;
  end

endmodule
